FILE: hw/rtl/tal_pkg.sv
// Shared types and constants for the tag allowlist block.
// Used by the top level tag_allowlist_enroll_remove; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tal_pkg;

    // Fixed field widths of the item channels.
    localparam int KEY_W     = 60;
    localparam int ID_BYTES  = 7;
    localparam int COUNT_W   = 5;
    localparam int SLOT_W    = 4;
    localparam int WINDOW_W  = 16;
    localparam int TIME_W    = 32;

    // Defaults for the top-level parameters.
    localparam int TABLE_SLOTS_DEF = 4;
    localparam int KEY_BYTES_DEF   = 7;

    // Configuration port.
    localparam int          PADDR_W           = 3;
    localparam logic        REG_REPEAT_WINDOW = 1'b0;
    localparam logic [15:0] WINDOW_RESET      = 16'd4000;

    // Result kinds.
    typedef enum logic [2:0] {
        OUT_READ_FAILED = 3'd0,
        OUT_KNOWN_SHOWN = 3'd1,
        OUT_KNOWN_REMOVED = 3'd2,
        OUT_ENROLLED = 3'd3,
        OUT_EMPTY_REJECTED = 3'd4,
        OUT_TABLE_FULL = 3'd5
    } outcome_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tal_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instanced by the tag allowlist top level.
`timescale 1ns / 1ps
`default_nettype none

module tal_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read data registered from the address, in the cycle after it.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tag_allowlist_enroll_remove.sv
// Top level of the tag allowlist: key forming, table search, enrolment and removal.
// Depends on tal_pkg and on the RAM tal_ram, which holds the key table.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted item is one card read; exactly one result item follows it, in
// order. The block works on one item at a time. An item is first taken in,
// then each table entry is compared in turn (the key table sits in a RAM
// with one read port and a registered read, so the search walks one slot a
// cycle), then for a removal each later entry is moved down a slot, and
// finally an enrolment is decided (on a miss) and the output register is
// loaded. A failed read goes straight from intake to loading the output
// register. The longest case is an unknown card against a full table.
// Loading the output register waits while an earlier result is still held
// there. The next item is taken while the previous result still waits in
// the output register. repeat_window_ms sits at byte address 0 of the
// register port and resets to 4000. The entry count and last key seen are
// cleared by reset, but the table is not; no clearing pass is needed, as
// only the first entry_count slots are ever compared.
module tag_allowlist_enroll_remove #(
    parameter int TABLE_SLOTS = tal_pkg::TABLE_SLOTS_DEF,
    parameter int KEY_BYTES   = tal_pkg::KEY_BYTES_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Input items.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // s_tdata: id_length [3:0], id_bytes [59:4], time_ms [91:60], zero fill.
    input  wire logic [95:0]                 s_tdata,
    // s_tuser: read_ok [0].
    input  wire logic [0:0]                  s_tuser,
    // Result items.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // m_tdata: slot [3:0], entry_count [8:4], zero fill.
    output logic [15:0]                      m_tdata,
    // m_tuser: outcome [2:0].
    output logic [2:0]                       m_tuser,
    // Register port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [tal_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    import tal_pkg::*;

    localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [COUNT_W-1:0] SLOTS_C = COUNT_W'(TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_MISS,
        S_EMIT
    } state_t;

    state_t                state_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [AW-1:0]         idx_reg;
    logic [COUNT_W-1:0]    key_count_reg;
    logic [KEY_W-1:0]      last_key_reg;
    logic [TIME_W-1:0]     last_time_reg;
    logic [WINDOW_W-1:0]   window_reg;
    outcome_t              res_outcome_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  m_tvalid_reg;
    outcome_t              m_outcome_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic                  s_accept;
    logic                  cfg_write;
    logic [KEY_W-1:0]      in_key;
    logic [COUNT_W-1:0]    idx_p1;
    logic [COUNT_W-1:0]    idx_p2;
    logic                  hit;
    logic                  repeat_read;
    logic                  ram_wr_en;
    logic [AW-1:0]         ram_wr_addr;
    logic [KEY_W-1:0]      ram_wr_data;
    logic                  ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [KEY_W-1:0]      ram_rd_data;

    // Key from a card read: length class in the top nibble, kept bytes below.
    function automatic logic [KEY_W-1:0] form_key(input logic [3:0]  len,
                                                 input logic [55:0] bytes);
        logic [3:0]  cls;
        logic [3:0]  kept;
        logic [55:0] kept_bytes;
        cls  = (len <= 4'(KEY_BYTES)) ? len : 4'(KEY_BYTES + 1);
        kept = len;
        if (kept > 4'(KEY_BYTES)) begin
            kept = 4'(KEY_BYTES);
        end
        if (kept > 4'(ID_BYTES)) begin
            kept = 4'(ID_BYTES);
        end
        for (int b = 0; b < ID_BYTES; b++) begin
            kept_bytes[55 - 8 * b -: 8] = (4'(b) < kept) ? bytes[55 - 8 * b -: 8] : 8'h00;
        end
        return {cls, kept_bytes};
    endfunction

    // Handshakes.
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    assign in_key = form_key(s_tdata[3:0], s_tdata[59:4]);

    // Slot arithmetic, kept at the entry-count width, wider than a slot index.
    assign idx_p1 = COUNT_W'(idx_reg) + COUNT_W'(1);
    assign idx_p2 = COUNT_W'(idx_reg) + COUNT_W'(2);

    // Comparison of the entry read last cycle and the repeat test.
    assign hit         = (ram_rd_data == key_reg);
    assign repeat_read = (last_key_reg == key_reg)
                      && ((now_reg - last_time_reg) <= TIME_W'(window_reg));

    // RAM read port: slot 0 on accept, then the next slot while searching or moving down.
    always_comb begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        case (state_reg)
            S_IDLE: begin
                ram_rd_en = s_accept;
            end
            S_SEARCH: begin
                ram_rd_en   = (idx_p1 < key_count_reg);
                ram_rd_addr = AW'(idx_p1);
            end
            S_SHIFT: begin
                ram_rd_en   = (idx_p2 < key_count_reg);
                ram_rd_addr = AW'(idx_p2);
            end
            default: begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // RAM write port: moved-down entries during removal, new key on enrolment.
    always_comb begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        case (state_reg)
            S_SHIFT: begin
                ram_wr_en = 1'b1;
            end
            S_MISS: begin
                ram_wr_en   = (key_count_reg < SLOTS_C) && (key_reg[KEY_W-1 -: 4] != 4'd0);
                ram_wr_addr = key_count_reg[AW-1:0];
                ram_wr_data = key_reg;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    tal_ram #(
        .WIDTH  (KEY_W),
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (AW)
    ) u_key_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Sequencer, table state, register and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            key_reg         <= '0;
            now_reg         <= '0;
            idx_reg         <= '0;
            key_count_reg   <= '0;
            last_key_reg    <= '0;
            last_time_reg   <= '0;
            window_reg      <= WINDOW_RESET;
            res_outcome_reg <= OUT_READ_FAILED;
            res_slot_reg    <= '0;
            m_tvalid_reg    <= 1'b0;
            m_outcome_reg   <= OUT_READ_FAILED;
            m_slot_reg      <= '0;
            m_count_reg     <= '0;
        end else begin
            if (cfg_write && (paddr[2] == REG_REPEAT_WINDOW)) begin
                window_reg <= pwdata[WINDOW_W-1:0];
            end
            // A taken result empties the output register unless a new one is loaded.
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        key_reg <= in_key;
                        now_reg <= s_tdata[91:60];
                        idx_reg <= '0;
                        if (!s_tuser[0]) begin
                            res_outcome_reg <= OUT_READ_FAILED;
                            res_slot_reg    <= '0;
                            state_reg       <= S_EMIT;
                        end else if (key_count_reg == '0) begin
                            state_reg <= S_MISS;
                        end else begin
                            state_reg <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    if (hit) begin
                        last_key_reg  <= key_reg;
                        last_time_reg <= now_reg;
                        res_slot_reg  <= SLOT_W'(idx_reg);
                        if (repeat_read) begin
                            res_outcome_reg <= OUT_KNOWN_REMOVED;
                            if (idx_p1 < key_count_reg) begin
                                state_reg <= S_SHIFT;
                            end else begin
                                key_count_reg <= key_count_reg - COUNT_W'(1);
                                state_reg     <= S_EMIT;
                            end
                        end else begin
                            res_outcome_reg <= OUT_KNOWN_SHOWN;
                            state_reg       <= S_EMIT;
                        end
                    end else if (idx_p1 < key_count_reg) begin
                        idx_reg <= AW'(idx_p1);
                    end else begin
                        state_reg <= S_MISS;
                    end
                end
                S_SHIFT: begin
                    // The entry read last cycle is written one slot lower in this cycle.
                    if (idx_p2 < key_count_reg) begin
                        idx_reg <= AW'(idx_p1);
                    end else begin
                        key_count_reg <= key_count_reg - COUNT_W'(1);
                        state_reg     <= S_EMIT;
                    end
                end
                S_MISS: begin
                    last_key_reg  <= key_reg;
                    last_time_reg <= now_reg;
                    res_slot_reg  <= '0;
                    if (key_count_reg < SLOTS_C) begin
                        if (key_reg[KEY_W-1 -: 4] == 4'd0) begin
                            res_outcome_reg <= OUT_EMPTY_REJECTED;
                        end else begin
                            res_outcome_reg <= OUT_ENROLLED;
                            key_count_reg   <= key_count_reg + COUNT_W'(1);
                        end
                    end else begin
                        res_outcome_reg <= OUT_TABLE_FULL;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg  <= 1'b1;
                        m_outcome_reg <= res_outcome_reg;
                        m_slot_reg    <= res_slot_reg;
                        m_count_reg   <= key_count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Output and register read-back.
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_outcome_reg;
    assign m_tdata  = {7'd0, m_count_reg, m_slot_reg};
    assign prdata   = (paddr[2] == REG_REPEAT_WINDOW) ? {16'd0, window_reg} : 32'd0;

`ifndef NO_ASSERTIONS
    // The entry count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= SLOTS_C)
        else $error("entry count exceeds table size");

    // Table writes land only below the count, or at the first free slot on enrolment.
    a_write_place: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> ((state_reg == S_SHIFT) && (idx_p1 < key_count_reg))
                   || ((state_reg == S_MISS) && (key_count_reg < SLOTS_C)))
        else $error("key table written outside the live entries");

    // The count holds while the block waits for an item.
    a_count_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |=> $stable(key_count_reg))
        else $error("entry count changed while idle");

    // Only results for a known card carry a slot.
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (m_outcome_reg != OUT_KNOWN_SHOWN)
         && (m_outcome_reg != OUT_KNOWN_REMOVED)) |-> (m_slot_reg == '0))
        else $error("slot set on a result without a match");
`endif

endmodule

`default_nettype wire
